>>> sv/bucketed_hash_kv_table_defines.svh
// ----------------------------------------------------------------------------
// Bucketed hash key-value table: assertion macros
// Shared assertion helpers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_KV_TABLE_DEFINES_SVH
`define BUCKETED_HASH_KV_TABLE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HKV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hkv_pkg.sv
// ----------------------------------------------------------------------------
// Bucketed hash key-value table: package
// Sizes, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package hkv_pkg;

    // Table geometry; the bucket is taken from the low key bits, so the
    // bucket count stays a power of two
    localparam int BUCKETS = 16;
    localparam int WAYS    = 2;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Field widths
    localparam int MODE_W = 2;
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EXISTS = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_BADKEY   = 3'd5;

    // Value returned when no stored value is read
    localparam logic [VAL_W-1:0] NO_VALUE = '1;

    // One bucket row of the key and value memories
    typedef logic [WAYS-1:0][KEY_W-1:0] key_row_t;
    typedef logic [WAYS-1:0][VAL_W-1:0] val_row_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the command word and read its bucket row
        logic commit;   // finish the command and load the result register
    } hkv_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a new word this cycle
    } hkv_sts_t;

endpackage

`default_nettype wire

>>> sv/bucketed_hash_kv_table.sv
// ----------------------------------------------------------------------------
// Bucketed hash key-value table
// Key-value store of 16 buckets with 2 slots each; set, get, delete, exists.
// ----------------------------------------------------------------------------
// For each command, in the accept cycle the key's bucket row (key and value
// of every way) is read from the row memories into a register; in the
// execute state that follows, all ways are compared, the row is written
// back and the result word is loaded into the output register. That single
// memory port with its registered read means a new command is taken only
// once the last one has executed. The execute cycle waits while the output
// register still holds an untaken word. Key 0 is answered with the bad-key
// status and changes nothing. All slot valid bits clear at reset, so the
// table is usable in the first cycle after reset.
`default_nettype none

module bucketed_hash_kv_table
    import hkv_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [MODE_W-1:0]       mode,
    input  wire logic [KEY_W-1:0]        key,
    input  wire logic signed [VAL_W-1:0] write_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [STAT_W-1:0]            status,
    output logic                         hit,
    output logic signed [VAL_W-1:0]      read_value
);

    hkv_cmd_t cmd;
    hkv_sts_t sts;

    // Sequence each command word
    hkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the table and compute results
    hkv_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .mode        (mode),
        .key         (key),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .hit         (hit),
        .read_value  (read_value)
    );

endmodule

`default_nettype wire

>>> sv/hkv_ctrl.sv
// ----------------------------------------------------------------------------
// Bucketed hash key-value table: controller
// Two-state sequencer: accept a command, then execute it once the result
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module hkv_ctrl
    import hkv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire hkv_sts_t sts,
    output hkv_cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Accept only while idle; the row read runs in the accept cycle
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = in_valid && in_ready;
    assign cmd.commit = (state_reg == S_EXEC) && sts.out_free;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/hkv_dp.sv
// ----------------------------------------------------------------------------
// Bucketed hash key-value table: datapath
// Key and value memories by bucket row, valid flops, way compare, result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bucketed_hash_kv_table_defines.svh"

module hkv_dp
    import hkv_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire hkv_cmd_t                cmd,
    output hkv_sts_t                     sts,
    input  wire logic [MODE_W-1:0]       mode,
    input  wire logic [KEY_W-1:0]        key,
    input  wire logic signed [VAL_W-1:0] write_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [STAT_W-1:0]            status,
    output logic                         hit,
    output logic signed [VAL_W-1:0]      read_value
);

    // Bucket row memories; entries are undefined until written
    key_row_t key_mem [BUCKETS];
    val_row_t val_mem [BUCKETS];

    // Captured command word
    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  wval_reg;

    // Registered bucket row read
    key_row_t rkey_reg;
    val_row_t rval_reg;

    // Per-slot valid bits
    logic [WAYS-1:0] valid_reg [BUCKETS];

    // Result register
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic              hit_reg;
    logic [VAL_W-1:0]  read_value_reg;

    logic [BKT_W-1:0]  bkt;
    logic [BKT_W-1:0]  in_bkt;
    logic [WAYS-1:0]   vrow;
    logic [WAYS-1:0]   match;
    logic              m_found;
    logic [WAY_W-1:0]  m_idx;
    logic              f_found;
    logic [WAY_W-1:0]  f_idx;
    logic              bad_key;
    logic [STAT_W-1:0] status_next;
    logic [VAL_W-1:0]  read_value_next;
    logic              row_we;
    logic              set_valid;
    logic              clr_valid;
    key_row_t          wkey_row;
    val_row_t          wval_row;

    // Bucket is the key modulo the bucket count (a power of two)
    assign in_bkt = key[BKT_W-1:0];
    assign bkt    = key_reg[BKT_W-1:0];
    assign vrow   = valid_reg[bkt];

    // Compare all ways of the bucket, pick the lowest match and free way
    always_comb
    begin
        m_found = 1'b0;
        m_idx   = '0;
        f_found = 1'b0;
        f_idx   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = vrow[w] && (rkey_reg[w] == key_reg);
            if (!m_found && match[w])
            begin
                m_found = 1'b1;
                m_idx   = WAY_W'(w);
            end
            if (!f_found && !vrow[w])
            begin
                f_found = 1'b1;
                f_idx   = WAY_W'(w);
            end
        end
    end

    assign bad_key = (key_reg == '0);

    // Decide the result and the table update
    always_comb
    begin
        status_next     = ST_NOTFOUND;
        read_value_next = NO_VALUE;
        row_we          = 1'b0;
        set_valid       = 1'b0;
        clr_valid       = 1'b0;
        wkey_row        = rkey_reg;
        wval_row        = rval_reg;
        if (bad_key)
        begin
            status_next = ST_BADKEY;
        end
        else
        begin
            unique case (mode_reg)
                MODE_SET:
                begin
                    priority if (m_found)
                    begin
                        status_next        = ST_UPDATED;
                        row_we             = 1'b1;
                        wval_row[m_idx]    = wval_reg;
                    end
                    else if (f_found)
                    begin
                        status_next        = ST_INSERTED;
                        row_we             = 1'b1;
                        set_valid          = 1'b1;
                        wkey_row[f_idx]    = key_reg;
                        wval_row[f_idx]    = wval_reg;
                    end
                    else
                    begin
                        status_next        = ST_NOSPACE;
                    end
                end
                MODE_GET:
                begin
                    if (m_found)
                    begin
                        status_next     = ST_INSERTED;
                        read_value_next = rval_reg[m_idx];
                    end
                end
                MODE_DELETE:
                begin
                    if (m_found)
                    begin
                        status_next = ST_DELETED;
                        clr_valid   = 1'b1;
                    end
                end
                MODE_EXISTS:
                begin
                    if (m_found)
                    begin
                        status_next = ST_INSERTED;
                    end
                end
                default:
                begin
                    status_next = ST_NOTFOUND;
                end
            endcase
        end
    end

    // Capture the command word and read its bucket row
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            wval_reg <= write_value;
            rkey_reg <= key_mem[in_bkt];
            rval_reg <= val_mem[in_bkt];
        end
    end

    // Write back the merged bucket row
    always_ff @(posedge clk)
    begin
        if (cmd.commit && row_we)
        begin
            key_mem[bkt] <= wkey_row;
            val_mem[bkt] <= wval_row;
        end
    end

    // Update valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (set_valid)
            begin
                valid_reg[bkt][f_idx] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[bkt][m_idx] <= 1'b0;
            end
        end
    end

    // Result word valid: load on commit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg     <= status_next;
            hit_reg        <= m_found && !bad_key;
            read_value_reg <= read_value_next;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign hit          = hit_reg;
    assign read_value   = read_value_reg;

    // A hit only comes with a hit status
    `HKV_ASSERT_SAME(a_hit_status, out_valid_reg && hit_reg, (status_reg == ST_UPDATED) || (status_reg == ST_INSERTED) || (status_reg == ST_DELETED), "hit with a miss status")
    // A miss never returns a stored value
    `HKV_ASSERT_SAME(a_miss_value, out_valid_reg && !hit_reg, read_value_reg == NO_VALUE, "miss returned a value")
    // A rejected key never hits
    `HKV_ASSERT_SAME(a_badkey_nohit, out_valid_reg && (status_reg == ST_BADKEY), !hit_reg, "bad key hit")
    // A commit always presents a result next cycle
    `HKV_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid_reg, "commit lost its result")

endmodule

`default_nettype wire
